@@ hdl/lcd_mode_stat_sequencer_macros.svh @@
// Assertion macros shared by the LCD mode/STAT sequencer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef LCD_MODE_STAT_SEQUENCER_MACROS_SVH
`define LCD_MODE_STAT_SEQUENCER_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define LCDMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define LCDMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/lcdms_pkg.sv @@
// Shared types, constants and helpers for the LCD mode/STAT sequencer.
// No dependencies; imported by lcdms_step and lcd_mode_stat_sequencer.
package lcdms_pkg;

  localparam logic [9:0] DOTS_PER_LINE = 10'd456;
  localparam logic [9:0] OAM_DOTS      = 10'd80;
  localparam logic [9:0] DOT_MAX       = 10'd1023;
  localparam logic [7:0] VBLANK_LINE   = 8'd144;
  localparam logic [7:0] LAST_LINE     = 8'd153;
  localparam logic       STAT_FIXED    = 1'b1;

  // Output mode codes
  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_OAM      = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes
  localparam logic CFG_COMPARE_LINE = 1'b0;
  localparam logic CFG_STAT_ENABLES = 1'b1;

  // Enable bit positions inside stat_enables
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COINC  = 3;

  typedef enum logic [3:0] {
    ST_HBLANK   = 4'b0001,
    ST_VBLANK   = 4'b0010,
    ST_OAM      = 4'b0100,
    ST_TRANSFER = 4'b1000
  } mode_state_t;

  typedef struct packed {
    logic [9:0]  dot_count;
    logic [7:0]  line_count;
    mode_state_t mode;
    logic        irq_line;
    logic        coincide_flag;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic [7:0] stat_value;
    logic       vblank_irq;
    logic       stat_irq;
    logic       hblank_start;
  } seq_result_t;

  function automatic logic [1:0] mode_code(input mode_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_HBLANK:   code = MODE_HBLANK;
      ST_VBLANK:   code = MODE_VBLANK;
      ST_OAM:      code = MODE_OAM;
      ST_TRANSFER: code = MODE_TRANSFER;
      default:     code = MODE_HBLANK;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/lcdms_step.sv @@
// Next-state and result logic for one tick of the LCD mode/STAT sequencer.
// Depends on lcdms_pkg; purely combinational, registered by the top level.
module lcdms_step import lcdms_pkg::*; (
  input  seq_state_t  cur,
  input  logic [7:0]  compare_line,
  input  logic [3:0]  stat_enables,
  input  logic [5:0]  dots,
  input  logic        lcd_on,
  input  logic        line_done,
  output seq_state_t  nxt,
  output seq_result_t res
);

  logic [10:0] dot_sum;
  logic [9:0]  dot_sat;
  logic [7:0]  line_inc;
  logic        line_end;
  logic        vbl;
  logic        oam_vbl_req;
  logic        hstart;
  logic        sig;
  logic        coinc;
  seq_state_t  upd;

  assign dot_sum  = {1'b0, cur.dot_count} + {5'b0, dots};
  assign dot_sat  = dot_sum[10] ? DOT_MAX : dot_sum[9:0];
  assign line_inc = cur.line_count + 8'd1;
  assign line_end = (dot_sat >= DOTS_PER_LINE);

  always_comb begin
    upd            = cur;
    upd.dot_count  = dot_sat;
    vbl            = 1'b0;
    oam_vbl_req    = 1'b0;
    hstart         = 1'b0;
    unique case (cur.mode)
      ST_HBLANK: begin
        if (line_end) begin
          upd.dot_count  = '0;
          upd.line_count = line_inc;
          if (line_inc == VBLANK_LINE) begin
            upd.mode    = ST_VBLANK;
            vbl         = 1'b1;
            oam_vbl_req = stat_enables[EN_OAM] & ~cur.irq_line;
          end else begin
            upd.mode = ST_OAM;
          end
        end
      end
      ST_VBLANK: begin
        if (line_end) begin
          upd.dot_count = '0;
          if (line_inc > LAST_LINE) begin
            upd.line_count = '0;
            upd.mode       = ST_OAM;
          end else begin
            upd.line_count = line_inc;
          end
        end
      end
      ST_OAM: begin
        if (dot_sat >= OAM_DOTS) upd.mode = ST_TRANSFER;
      end
      ST_TRANSFER: begin
        if (line_done) begin
          upd.mode = ST_HBLANK;
          hstart   = 1'b1;
        end
      end
      default: upd.mode = ST_HBLANK;
    endcase
  end

  always_comb begin
    unique case (upd.mode)
      ST_HBLANK: sig = stat_enables[EN_HBLANK];
      ST_VBLANK: sig = stat_enables[EN_VBLANK];
      ST_OAM:    sig = stat_enables[EN_OAM];
      default:   sig = 1'b0;
    endcase
  end

  assign coinc = (compare_line == upd.line_count);

  always_comb begin
    if (lcd_on) begin
      nxt               = upd;
      nxt.coincide_flag = coinc;
      nxt.irq_line      = sig | (stat_enables[EN_COINC] & coinc);
      res.vblank_irq    = vbl;
      res.stat_irq      = oam_vbl_req | (~cur.irq_line & nxt.irq_line);
      res.hblank_start  = hstart;
    end else begin
      nxt.dot_count     = '0;
      nxt.line_count    = '0;
      nxt.mode          = ST_HBLANK;
      nxt.irq_line      = 1'b0;
      nxt.coincide_flag = cur.coincide_flag;
      res.vblank_irq    = 1'b0;
      res.stat_irq      = 1'b0;
      res.hblank_start  = 1'b0;
    end
    res.lcd_mode    = mode_code(nxt.mode);
    res.line_number = nxt.line_count;
    res.stat_value  = {STAT_FIXED, stat_enables, nxt.coincide_flag, mode_code(nxt.mode)};
  end

endmodule

@@ hdl/lcd_mode_stat_sequencer.sv @@
// Top level of the LCD line/mode sequencer with STAT and vblank requests.
// Depends on lcdms_pkg, lcdms_step and lcd_mode_stat_sequencer_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick item: dots elapsed,
//   the LCD enable and the pixel pipeline's line_done flag.
//   Output channel (out_valid/out_ready) returns exactly one result item per
//   tick: mode, line, STAT read value and the interrupt / HDMA strobes.
//   Configuration (cfg_we, cfg_index, cfg_data) writes compare_line (index 0)
//   or stat_enables (index 1, low four data bits); write only while idle.
// Timing:
//   A tick is accepted, its next state computed by lcdms_step and stored in
//   the sequencer registers and the result register at the same edge, so the
//   result is valid in the cycle after acceptance. One tick per cycle is
//   sustained while out_ready stays high; a low out_ready holds the flow.
// Reset:
//   rst clears the counter, line, mode, STAT line, coincidence flag and both
//   configuration registers, and drops out_valid.
// Stall:
//   While out_ready is low a held result blocks in_ready; the tick waits at
//   the input and the sequencer state does not move.
`include "lcd_mode_stat_sequencer_macros.svh"

module lcd_mode_stat_sequencer import lcdms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // tick input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] dots,
  input  logic       lcd_on,
  input  logic       line_done,
  // result output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] lcd_mode,
  output logic [7:0] line_number,
  output logic [7:0] stat_value,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       hblank_start
);

  logic [7:0]  compare_line;
  logic [3:0]  stat_enables;
  seq_state_t  state;
  seq_state_t  state_next;
  seq_result_t result;
  seq_result_t result_next;
  logic        in_fire;

  // Accept a new tick whenever the result register is empty or being drained.
  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_line <= '0;
      stat_enables <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPARE_LINE: compare_line <= cfg_data;
        CFG_STAT_ENABLES: stat_enables <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lcdms_step u_step (
    .cur          (state),
    .compare_line (compare_line),
    .stat_enables (stat_enables),
    .dots         (dots),
    .lcd_on       (lcd_on),
    .line_done    (line_done),
    .nxt          (state_next),
    .res          (result_next)
  );

  // Sequencer state: advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.dot_count     <= '0;
      state.line_count    <= '0;
      state.mode          <= ST_HBLANK;
      state.irq_line      <= 1'b0;
      state.coincide_flag <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register: load on accept, drop valid once taken with no new tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign lcd_mode     = result.lcd_mode;
  assign line_number  = result.line_number;
  assign stat_value   = result.stat_value;
  assign vblank_irq   = result.vblank_irq;
  assign stat_irq     = result.stat_irq;
  assign hblank_start = result.hblank_start;

  // Visible lines only outside vblank; vblank lines only inside it.
  `LCDMS_ASSERT(a_line_vs_mode,
    (state.mode == ST_VBLANK) ?
      (state.line_count >= VBLANK_LINE && state.line_count <= LAST_LINE) :
      (state.line_count < VBLANK_LINE),
    "line count inconsistent with mode")
  // A vblank request always reports entry to the first vblank line.
  `LCDMS_ASSERT(a_vblank_entry,
    (out_valid && vblank_irq) |-> (lcd_mode == MODE_VBLANK && line_number == VBLANK_LINE),
    "vblank request outside vblank entry")
  // The HDMA trigger only accompanies hblank.
  `LCDMS_ASSERT(a_hstart_mode,
    (out_valid && hblank_start) |-> (lcd_mode == MODE_HBLANK),
    "hblank_start without hblank mode")
  // A tick with the LCD off leaves the sequencer cleared.
  `LCDMS_ASSERT(a_lcd_off_clear,
    (in_fire && !lcd_on) |=> (state.line_count == 8'd0 && state.dot_count == 10'd0 &&
                              state.mode == ST_HBLANK && !state.irq_line),
    "LCD off did not clear sequencer")

endmodule
